// ===== design/slc_pkg.sv =====
// Shared types and constants for the set-associative LRU cache simulator.
package slc_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_EVAL,
    ST_WRITE
  } state_t;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_STORE  = 2'd1;
  localparam logic [1:0] FUNC_MODIFY = 2'd2;
  localparam logic [1:0] FUNC_FETCH  = 2'd3;

  localparam logic [1:0] RES_IGNORED = 2'd0;
  localparam logic [1:0] RES_HIT     = 2'd1;
  localparam logic [1:0] RES_MISS    = 2'd2;
  localparam logic [1:0] RES_EVICT   = 2'd3;

  localparam logic [1:0] REG_SET_BITS = 2'd0;
  localparam logic [1:0] REG_OFF_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS     = 2'd2;

  localparam int FUNC_W      = 2;
  localparam int OUTCOME_W   = 2;
  localparam int TOTAL_W     = 32;
  localparam int SET_BITS_W  = 4;
  localparam int OFF_BITS_W  = 5;
  localparam int WAYS_W      = 4;
  localparam int SHIFT_W     = 6;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int OUT_FIELD_W = OUTCOME_W + 1 + 3 * TOTAL_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

endpackage

// ===== design/slc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module slc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/slc_victim.sv =====
// Registered-input comparison tree that picks the least recently used way.
module slc_victim #(
  parameter int WAYS  = 8,
  parameter int AGE_W = 32
) (
  input  logic [WAYS-1:0][AGE_W-1:0]               age,
  input  logic [WAYS-1:0]                          inuse,
  output logic [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0] way
);

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int PAD   = 1 << $clog2(WAYS);
  localparam int NODES = 2 * PAD - 1;

  logic             n_ok  [NODES];
  logic [AGE_W-1:0] n_age [NODES];
  logic [WAY_W-1:0] n_idx [NODES];

  always_comb begin
    for (int i = 0; i < PAD; i++) begin
      n_ok[PAD-1+i]  = 1'b0;
      n_age[PAD-1+i] = '0;
      n_idx[PAD-1+i] = WAY_W'(i);
      if (i < WAYS) begin
        n_ok[PAD-1+i]  = inuse[i];
        n_age[PAD-1+i] = age[i];
      end
    end
    for (int n = PAD - 2; n >= 0; n--) begin
      if (n_ok[2*n+2] && (!n_ok[2*n+1] || (n_age[2*n+2] > n_age[2*n+1]))) begin
        n_ok[n]  = n_ok[2*n+2];
        n_age[n] = n_age[2*n+2];
        n_idx[n] = n_idx[2*n+2];
      end else begin
        n_ok[n]  = n_ok[2*n+1];
        n_age[n] = n_age[2*n+1];
        n_idx[n] = n_idx[2*n+1];
      end
    end
    way = n_idx[0];
  end

endmodule

// ===== design/set_associative_lru_cache_sim.sv =====
// Top level of the set-associative LRU cache simulator.
// Each access item goes through acceptance with the set read issued to the valid and
// line memories, a compare step that forms hit flags and line ages, a step in which the
// age tree picks the victim, and a write-back step that updates the set (not for
// fetches), the access clock and the totals and loads the result register. A new item
// is taken only once the write-back is done, so items do not overlap; the write-back
// waits while the result register has not yet been taken. After reset the valid
// memory is swept clear, one set per cycle, over all 2**MAX_SET_BITS sets (1024 with
// the defaults), and in_tready stays low during that sweep; configuration writes are
// taken at any time.
module set_associative_lru_cache_sim #(
  parameter int MAX_WAYS     = 8,
  parameter int MAX_SET_BITS = 10,
  parameter int ADDR_WIDTH   = 48,
  parameter int STAMP_WIDTH  = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // in_tdata: address
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((ADDR_WIDTH + 7) / 8) * 8-1:0]  in_tdata,
  // in_tuser: func
  input  logic [slc_pkg::FUNC_W-1:0]             in_tuser,
  // out_tdata: outcome, extra_hit, hit_total, miss_total, eviction_total, zero fill
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [slc_pkg::OUT_TDATA_W-1:0]        out_tdata,
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [slc_pkg::CFG_ADDR_W-1:0]         cfg_paddr,
  input  logic [slc_pkg::CFG_DATA_W-1:0]         cfg_pwdata,
  output logic [slc_pkg::CFG_DATA_W-1:0]         cfg_prdata,
  output logic                                   cfg_pready
);

  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WC_W   = $clog2(MAX_WAYS + 1);
  localparam int SB_W   = $clog2(MAX_SET_BITS + 1);
  localparam int SETS   = 1 << MAX_SET_BITS;
  localparam int LINE_W = ADDR_WIDTH + STAMP_WIDTH;
  localparam int ROW_W  = MAX_WAYS * LINE_W;
  localparam int PAD_W  = slc_pkg::OUT_TDATA_W - slc_pkg::OUT_FIELD_W;

  slc_pkg::state_t state_r, state_nxt;

  logic [MAX_SET_BITS-1:0]         clr_cnt_r;
  logic [slc_pkg::SET_BITS_W-1:0]  set_bits_r;
  logic [slc_pkg::OFF_BITS_W-1:0]  off_bits_r;
  logic [slc_pkg::WAYS_W-1:0]      ways_r;
  logic [STAMP_WIDTH-1:0]          clock_r;
  logic [slc_pkg::TOTAL_W-1:0]     hits_r;
  logic [slc_pkg::TOTAL_W-1:0]     misses_r;
  logic [slc_pkg::TOTAL_W-1:0]     evicts_r;
  logic                            out_valid_r;
  logic [slc_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic [ADDR_WIDTH-1:0]           tag_r;
  logic [MAX_SET_BITS-1:0]         set_r;
  logic [slc_pkg::FUNC_W-1:0]      func_r;
  logic [MAX_WAYS-1:0]             inuse_r;
  logic [MAX_WAYS-1:0]             match_r;
  logic [MAX_WAYS-1:0]             free_r;
  logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0] age_r;
  logic [ROW_W-1:0]                row_r;
  logic [MAX_WAYS-1:0]             vrow_r;
  logic [WAY_W-1:0]                way_r;
  logic [slc_pkg::OUTCOME_W-1:0]   outcome_r;

  logic [ADDR_WIDTH-1:0]           addr;
  logic [SB_W-1:0]                 sbits;
  logic [slc_pkg::SHIFT_W-1:0]     shift;
  logic [ADDR_WIDTH-1:0]           set_shifted;
  logic [MAX_SET_BITS-1:0]         set_mask;
  logic [MAX_SET_BITS-1:0]         set_nxt;
  logic [ADDR_WIDTH-1:0]           tag_nxt;
  logic [WC_W-1:0]                 ways_c;
  logic [MAX_WAYS-1:0]             inuse_nxt;

  logic                            vram_we;
  logic [MAX_SET_BITS-1:0]         vram_waddr;
  logic [MAX_WAYS-1:0]             vram_wdata;
  logic [MAX_WAYS-1:0]             vram_rdata;
  logic                            lram_we;
  logic [ROW_W-1:0]                lram_wdata;
  logic [ROW_W-1:0]                lram_rdata;

  logic                            accept;
  logic                            cfg_wr;
  logic                            wb_go;
  logic [MAX_WAYS-1:0]             vrow_now;
  logic [WAY_W-1:0]                lru_way;
  logic [WAY_W-1:0]                hit_way;
  logic [WAY_W-1:0]                free_way;
  logic [WAY_W-1:0]                way_nxt;
  logic [slc_pkg::OUTCOME_W-1:0]   outcome_nxt;
  logic [slc_pkg::TOTAL_W-1:0]     hits_a;
  logic [slc_pkg::TOTAL_W-1:0]     hits_nxt;
  logic [slc_pkg::TOTAL_W-1:0]     misses_nxt;
  logic [slc_pkg::TOTAL_W-1:0]     evicts_nxt;
  logic                            extra;

  assign accept     = in_tvalid && in_tready;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign wb_go      = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    case (cfg_paddr[3:2])
      slc_pkg::REG_SET_BITS: cfg_prdata = slc_pkg::CFG_DATA_W'(set_bits_r);
      slc_pkg::REG_OFF_BITS: cfg_prdata = slc_pkg::CFG_DATA_W'(off_bits_r);
      slc_pkg::REG_WAYS:     cfg_prdata = slc_pkg::CFG_DATA_W'(ways_r);
      default:               cfg_prdata = '0;
    endcase
  end

  // Address split and way mask, taken from the configuration at acceptance.
  always_comb begin
    addr = in_tdata[ADDR_WIDTH-1:0];
    if (32'(set_bits_r) > MAX_SET_BITS) begin
      sbits = SB_W'(MAX_SET_BITS);
    end else begin
      sbits = SB_W'(set_bits_r);
    end
    shift       = slc_pkg::SHIFT_W'(sbits) + slc_pkg::SHIFT_W'(off_bits_r);
    set_shifted = addr >> off_bits_r;
    set_mask    = ~({MAX_SET_BITS{1'b1}} << sbits);
    set_nxt     = set_shifted[MAX_SET_BITS-1:0] & set_mask;
    if (int'(shift) < ADDR_WIDTH) begin
      tag_nxt = addr >> shift;
    end else begin
      tag_nxt = '0;
    end
    if (ways_r == '0) begin
      ways_c = WC_W'(1);
    end else if (32'(ways_r) > MAX_WAYS) begin
      ways_c = WC_W'(MAX_WAYS);
    end else begin
      ways_c = WC_W'(ways_r);
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      inuse_nxt[w] = (w < int'(ways_c));
    end
  end

  slc_ram #(
    .WIDTH (MAX_WAYS),
    .DEPTH (SETS)
  ) u_valid_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .raddr (set_nxt),
    .rdata (vram_rdata)
  );

  slc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_line_ram (
    .clk   (clk),
    .we    (lram_we),
    .waddr (set_r),
    .wdata (lram_wdata),
    .raddr (set_nxt),
    .rdata (lram_rdata)
  );

  slc_victim #(
    .WAYS  (MAX_WAYS),
    .AGE_W (STAMP_WIDTH)
  ) u_victim (
    .age   (age_r),
    .inuse (inuse_r),
    .way   (lru_way)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      slc_pkg::ST_CLEAR: begin
        if (clr_cnt_r == '1) begin
          state_nxt = slc_pkg::ST_IDLE;
        end
      end
      slc_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = slc_pkg::ST_LOOK;
        end
      end
      slc_pkg::ST_LOOK:  state_nxt = slc_pkg::ST_EVAL;
      slc_pkg::ST_EVAL:  state_nxt = slc_pkg::ST_WRITE;
      slc_pkg::ST_WRITE: begin
        if (wb_go) begin
          state_nxt = slc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = slc_pkg::ST_IDLE;
    endcase
  end

  // Memory write-back data for the selected way.
  always_comb begin
    lram_wdata = row_r;
    lram_wdata[int'(way_r)*LINE_W +: LINE_W] = {clock_r, tag_r};
    vrow_now = vrow_r;
    vrow_now[way_r] = 1'b1;
  end

  // Outputs of the sequencer.
  always_comb begin
    in_tready  = 1'b0;
    vram_we    = 1'b0;
    vram_waddr = set_r;
    vram_wdata = vrow_now;
    lram_we    = 1'b0;
    case (state_r)
      slc_pkg::ST_CLEAR: begin
        vram_we    = 1'b1;
        vram_waddr = clr_cnt_r;
        vram_wdata = '0;
      end
      slc_pkg::ST_IDLE: in_tready = 1'b1;
      slc_pkg::ST_WRITE: begin
        if (wb_go && (func_r != slc_pkg::FUNC_FETCH)) begin
          vram_we = 1'b1;
          lram_we = 1'b1;
        end
      end
      default: in_tready = 1'b0;
    endcase
  end

  // Hit and free-way selection, lowest way first.
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match_r[w]) begin
        hit_way = WAY_W'(w);
      end
      if (free_r[w]) begin
        free_way = WAY_W'(w);
      end
    end
    if (func_r == slc_pkg::FUNC_FETCH) begin
      outcome_nxt = slc_pkg::RES_IGNORED;
      way_nxt     = '0;
    end else if (|match_r) begin
      outcome_nxt = slc_pkg::RES_HIT;
      way_nxt     = hit_way;
    end else if (|free_r) begin
      outcome_nxt = slc_pkg::RES_MISS;
      way_nxt     = free_way;
    end else begin
      outcome_nxt = slc_pkg::RES_EVICT;
      way_nxt     = lru_way;
    end
  end

  // Running totals after this item.
  always_comb begin
    extra  = (func_r == slc_pkg::FUNC_MODIFY);
    hits_a = hits_r;
    if ((outcome_r == slc_pkg::RES_HIT) && (hits_r != slc_pkg::TOTAL_MAX)) begin
      hits_a = hits_r + 1'b1;
    end
    hits_nxt = hits_a;
    if (extra && (hits_a != slc_pkg::TOTAL_MAX)) begin
      hits_nxt = hits_a + 1'b1;
    end
    misses_nxt = misses_r;
    if (((outcome_r == slc_pkg::RES_MISS) || (outcome_r == slc_pkg::RES_EVICT)) &&
        (misses_r != slc_pkg::TOTAL_MAX)) begin
      misses_nxt = misses_r + 1'b1;
    end
    evicts_nxt = evicts_r;
    if ((outcome_r == slc_pkg::RES_EVICT) && (evicts_r != slc_pkg::TOTAL_MAX)) begin
      evicts_nxt = evicts_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slc_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      set_bits_r  <= slc_pkg::SET_BITS_W'(4);
      off_bits_r  <= slc_pkg::OFF_BITS_W'(4);
      ways_r      <= slc_pkg::WAYS_W'(1);
      clock_r     <= STAMP_WIDTH'(1);
      hits_r      <= '0;
      misses_r    <= '0;
      evicts_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == slc_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          slc_pkg::REG_SET_BITS: set_bits_r <= cfg_pwdata[slc_pkg::SET_BITS_W-1:0];
          slc_pkg::REG_OFF_BITS: off_bits_r <= cfg_pwdata[slc_pkg::OFF_BITS_W-1:0];
          slc_pkg::REG_WAYS:     ways_r     <= cfg_pwdata[slc_pkg::WAYS_W-1:0];
          default: ;
        endcase
      end
      if ((state_r == slc_pkg::ST_WRITE) && wb_go) begin
        clock_r     <= clock_r + 1'b1;
        hits_r      <= hits_nxt;
        misses_r    <= misses_nxt;
        evicts_r    <= evicts_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_r   <= tag_nxt;
      set_r   <= set_nxt;
      func_r  <= in_tuser;
      inuse_r <= inuse_nxt;
    end
    if (state_r == slc_pkg::ST_LOOK) begin
      row_r  <= lram_rdata;
      vrow_r <= vram_rdata;
      for (int w = 0; w < MAX_WAYS; w++) begin
        match_r[w] <= inuse_r[w] && vram_rdata[w] &&
                      (lram_rdata[w*LINE_W +: ADDR_WIDTH] == tag_r);
        free_r[w]  <= inuse_r[w] && !vram_rdata[w];
        age_r[w]   <= clock_r - lram_rdata[w*LINE_W+ADDR_WIDTH +: STAMP_WIDTH];
      end
    end
    if (state_r == slc_pkg::ST_EVAL) begin
      way_r     <= way_nxt;
      outcome_r <= outcome_nxt;
    end
    if ((state_r == slc_pkg::ST_WRITE) && wb_go) begin
      out_data_r <= {{PAD_W{1'b0}}, evicts_nxt, misses_nxt, hits_nxt, extra, outcome_r};
    end
  end

endmodule

// ===== bench/slc_checker.sv =====
// Checker for the cache simulator: predicts each access result, checks it and register reads.
module slc_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [47:0]                      in_tdata,
  input  logic [slc_pkg::FUNC_W-1:0]       in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [slc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [slc_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [slc_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  input  logic [slc_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  input  logic                             cfg_pready,
  output int                               errors,
  output int                               pending,
  output int                               checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NWAYS = 8;
  localparam int NSETBITS = 10;
  localparam int AW = 48;
  localparam int NLINES = NWAYS << NSETBITS;

  // Packed from the highest bit down, so the outcome lands in the lowest bits.
  typedef struct packed {
    logic [slc_pkg::TOTAL_W-1:0]   eviction_total;
    logic [slc_pkg::TOTAL_W-1:0]   miss_total;
    logic [slc_pkg::TOTAL_W-1:0]   hit_total;
    logic                          extra_hit;
    logic [slc_pkg::OUTCOME_W-1:0] outcome;
  } access_result_t;

  bit                  line_valid [NLINES];
  logic [AW-1:0]       line_tag   [NLINES];
  logic [31:0]         line_stamp [NLINES];
  logic [31:0]         access_clock;
  logic [slc_pkg::TOTAL_W-1:0]  hit_count, miss_count, evict_count;
  logic [slc_pkg::SET_BITS_W-1:0] set_bits;
  logic [slc_pkg::OFF_BITS_W-1:0] off_bits;
  logic [slc_pkg::WAYS_W-1:0]     way_count;

  access_result_t expected_results[$];

  function automatic logic [slc_pkg::TOTAL_W-1:0] bump(logic [slc_pkg::TOTAL_W-1:0] v);
    return (v == slc_pkg::TOTAL_MAX) ? v : v + 1'b1;
  endfunction

  function automatic access_result_t predict_access(logic [1:0] func, logic [AW-1:0] addr);
    access_result_t r;
    int sb, bb, nw, base, victim, w;
    logic [AW-1:0] tag, shifted;
    logic [31:0] age, best_age;
    bit hit, free_found;
    r.outcome = slc_pkg::RES_IGNORED;
    r.extra_hit = 1'b0;
    if (func != slc_pkg::FUNC_FETCH) begin
      sb = (set_bits > NSETBITS) ? NSETBITS : int'(set_bits);
      bb = int'(off_bits);
      nw = (way_count == 0) ? 1 : ((way_count > NWAYS) ? NWAYS : int'(way_count));
      tag = (sb + bb < AW) ? (addr >> (sb + bb)) : '0;
      shifted = addr >> bb;
      base = (int'(shifted[NSETBITS-1:0]) & ((1 << sb) - 1)) * NWAYS;
      hit = 1'b0;
      for (w = 0; w < nw; w++) begin
        if (!hit && line_valid[base+w] && line_tag[base+w] == tag) begin
          hit = 1'b1;
          line_stamp[base+w] = access_clock;
          hit_count = bump(hit_count);
          r.outcome = slc_pkg::RES_HIT;
        end
      end
      if (!hit) begin
        miss_count = bump(miss_count);
        r.outcome = slc_pkg::RES_MISS;
        victim = 0;
        free_found = 1'b0;
        for (w = 0; w < nw; w++) begin
          if (!free_found && !line_valid[base+w]) begin
            victim = w;
            free_found = 1'b1;
          end
        end
        if (!free_found) begin
          best_age = '0;
          for (w = 0; w < nw; w++) begin
            age = access_clock - line_stamp[base+w];
            if (w == 0 || age > best_age) begin
              best_age = age;
              victim = w;
            end
          end
          evict_count = bump(evict_count);
          r.outcome = slc_pkg::RES_EVICT;
        end
        line_valid[base+victim] = 1'b1;
        line_tag[base+victim] = tag;
        line_stamp[base+victim] = access_clock;
      end
      if (func == slc_pkg::FUNC_MODIFY) begin
        hit_count = bump(hit_count);
        r.extra_hit = 1'b1;
      end
    end
    access_clock = access_clock + 1'b1;
    r.hit_total = hit_count;
    r.miss_total = miss_count;
    r.eviction_total = evict_count;
    return r;
  endfunction

  access_result_t got, want;
  logic [slc_pkg::CFG_DATA_W-1:0] reg_value;

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NLINES; i++) line_valid[i] = 1'b0;
      access_clock = 32'd1;
      hit_count = '0;
      miss_count = '0;
      evict_count = '0;
      set_bits = 4'd4;
      off_bits = 5'd4;
      way_count = 4'd1;
      expected_results.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        case (cfg_paddr[3:2])
          slc_pkg::REG_SET_BITS:
            reg_value = {{(slc_pkg::CFG_DATA_W-slc_pkg::SET_BITS_W){1'b0}}, set_bits};
          slc_pkg::REG_OFF_BITS:
            reg_value = {{(slc_pkg::CFG_DATA_W-slc_pkg::OFF_BITS_W){1'b0}}, off_bits};
          slc_pkg::REG_WAYS:
            reg_value = {{(slc_pkg::CFG_DATA_W-slc_pkg::WAYS_W){1'b0}}, way_count};
          default: reg_value = '0;
        endcase
        if (cfg_pwrite) begin
          case (cfg_paddr[3:2])
            slc_pkg::REG_SET_BITS: set_bits = cfg_pwdata[slc_pkg::SET_BITS_W-1:0];
            slc_pkg::REG_OFF_BITS: off_bits = cfg_pwdata[slc_pkg::OFF_BITS_W-1:0];
            slc_pkg::REG_WAYS:     way_count = cfg_pwdata[slc_pkg::WAYS_W-1:0];
            default: ;
          endcase
        end else if (cfg_prdata !== reg_value) begin
          errors++;
          if (errors <= 10)
            $display("register %0d read back %h, expected %h", cfg_paddr[3:2],
                     cfg_prdata, reg_value);
        end
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[slc_pkg::OUT_FIELD_W-1:0];
        checked++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result item: outcome %0d extra %0d totals %0d/%0d/%0d",
                     got.outcome, got.extra_hit, got.hit_total, got.miss_total,
                     got.eviction_total);
        end else begin
          want = expected_results.pop_front();
          if (got.outcome !== want.outcome || got.extra_hit !== want.extra_hit ||
              got.hit_total !== want.hit_total || got.miss_total !== want.miss_total ||
              got.eviction_total !== want.eviction_total) begin
            errors++;
            if (errors <= 10)
              $display({"result %0d mismatch: outcome %0d/%0d extra %0d/%0d hits %0d/%0d",
                        " misses %0d/%0d evictions %0d/%0d (got/expected)"},
                       checked, got.outcome, want.outcome, got.extra_hit, want.extra_hit,
                       got.hit_total, want.hit_total, got.miss_total, want.miss_total,
                       got.eviction_total, want.eviction_total);
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_access(in_tuser, in_tdata));
    end
    pending = expected_results.size();
  end

endmodule

// ===== bench/tb.sv =====
// Testbench top: drives cache accesses and register settings into the simulator and reports.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid, in_tready;
  logic [47:0]                     in_tdata;
  logic [slc_pkg::FUNC_W-1:0]      in_tuser;
  logic                            out_tvalid, out_tready;
  logic [slc_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_psel, cfg_penable, cfg_pwrite;
  logic [slc_pkg::CFG_ADDR_W-1:0]  cfg_paddr;
  logic [slc_pkg::CFG_DATA_W-1:0]  cfg_pwdata, cfg_prdata;
  logic                            cfg_pready;

  int errors, pending, checked;
  int send_idle_pct, recv_stall_pct;
  int hold_requests, accesses_sent, settings_used;
  logic [47:0] line_pool [16];
  int pool_size, cur_bb;

  set_associative_lru_cache_sim dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  slc_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .errors(errors), .pending(pending), .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int hold_seen, hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_access(logic [1:0] func, logic [47:0] addr);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= addr;
    do @(posedge clk); while (!in_tready);
    accesses_sent++;
  endtask

  task automatic cfg_access(bit wr, logic [1:0] code, logic [slc_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= {code, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic apply_setting(int sb, int bb, int nw);
    logic [slc_pkg::CFG_DATA_W-1:0] noise;
    noise = $urandom;
    cfg_access(1'b1, slc_pkg::REG_SET_BITS, {noise[31:4], 4'(sb)});
    cfg_access(1'b0, slc_pkg::REG_SET_BITS, '0);
    noise = $urandom;
    cfg_access(1'b1, slc_pkg::REG_OFF_BITS, {noise[31:5], 5'(bb)});
    cfg_access(1'b0, slc_pkg::REG_OFF_BITS, '0);
    noise = $urandom;
    cfg_access(1'b1, slc_pkg::REG_WAYS, {noise[31:4], 4'(nw)});
    cfg_access(1'b0, slc_pkg::REG_WAYS, '0);
    settings_used++;
  endtask

  // Lines crowd into two sets so that hits and LRU evictions both occur often.
  task automatic build_pool(int sb, int bb, int nw);
    int sbe, nwe;
    logic [63:0] tag, set_a, set_b, line_set;
    sbe = (sb > 10) ? 10 : sb;
    nwe = (nw == 0) ? 1 : ((nw > 8) ? 8 : nw);
    pool_size = nwe + 3;
    cur_bb = bb;
    set_a = {$urandom, $urandom} & ((64'd1 << sbe) - 1);
    set_b = {$urandom, $urandom} & ((64'd1 << sbe) - 1);
    for (int i = 0; i < pool_size; i++) begin
      tag = {$urandom, $urandom};
      line_set = (i % 2 == 0) ? set_a : set_b;
      line_pool[i] = 48'((tag << (sbe + bb)) | (line_set << bb));
    end
  endtask

  task automatic random_access;
    logic [1:0] func;
    logic [63:0] addr;
    func = ($urandom_range(99) < 12) ? slc_pkg::FUNC_FETCH : 2'($urandom_range(2));
    if ($urandom_range(99) < 80)
      addr = {16'd0, line_pool[$urandom_range(pool_size - 1)]} |
             ({$urandom, $urandom} & ((64'd1 << cur_bb) - 1));
    else
      addr = {$urandom, $urandom};
    send_access(func, addr[47:0]);
  endtask

  initial begin
    int phase_sb [8] = '{0, 15, 2, 10, 1, 3, 4, 7};
    int phase_bb [8] = '{0, 31, 4, 16, 1, 6, 5, 2};
    int phase_nw [8] = '{0, 15, 4, 8, 2, 3, 9, 5};
    int idle_of_mode [4] = '{0, 84, 0, 30};
    int stall_of_mode [4] = '{0, 0, 84, 30};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = slc_pkg::FUNC_LOAD;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests = 0;
    accesses_sent = 0;
    settings_used = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: one way, sixteen sets, sixteen-byte blocks.
    send_access(slc_pkg::FUNC_LOAD, 48'h0);
    send_access(slc_pkg::FUNC_LOAD, 48'h0);
    send_access(slc_pkg::FUNC_STORE, 48'hF);
    send_access(slc_pkg::FUNC_MODIFY, 48'h0);
    send_access(slc_pkg::FUNC_FETCH, 48'h0);
    send_access(slc_pkg::FUNC_LOAD, 48'h10);
    send_access(slc_pkg::FUNC_LOAD, 48'h100);
    send_access(slc_pkg::FUNC_MODIFY, 48'h200);
    send_access(slc_pkg::FUNC_LOAD, 48'hFFFF_FFFF_FFFF);
    send_access(slc_pkg::FUNC_STORE, 48'hFFFF_FFFF_FFFF);
    send_access(slc_pkg::FUNC_FETCH, 48'hFFFF_FFFF_FFFF);
    send_access(slc_pkg::FUNC_MODIFY, 48'h8000_0000_0000);
    drain();

    // Eight ways: fill set zero, refresh the oldest line, then force an LRU eviction.
    apply_setting(4, 4, 8);
    for (int t = 1; t <= 8; t++) send_access(slc_pkg::FUNC_STORE, 48'(t) << 8);
    send_access(slc_pkg::FUNC_LOAD, 48'h100);
    send_access(slc_pkg::FUNC_LOAD, 48'h900);
    send_access(slc_pkg::FUNC_LOAD, 48'hA00);
    send_access(slc_pkg::FUNC_MODIFY, 48'h100);
    drain();

    for (int p = 0; p < 8; p++) begin
      apply_setting(phase_sb[p], phase_bb[p], phase_nw[p]);
      build_pool(phase_sb[p], phase_bb[p], phase_nw[p]);
      send_idle_pct = idle_of_mode[p % 4];
      recv_stall_pct = stall_of_mode[p % 4];
      if (p == 0) hold_requests++;
      for (int i = 0; i < 80; i++) begin
        random_access();
        if (i == 40 && $urandom_range(1) == 1) build_pool(phase_sb[p], phase_bb[p], phase_nw[p]);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("%0d accesses sent over %0d register settings, %0d result items compared",
             accesses_sent, settings_used, checked);
    $display("traffic ran with no idling, sender gaps, receiver stalls, both, and one long hold-off");
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
